// File: rtl/tcfq_pkg.sv
`default_nettype none
package tcfq_pkg;

  // request codes as they arrive on the input channel
  typedef logic [1:0] req_t;
  localparam req_t REQ_ENQ     = 2'd0;
  localparam req_t REQ_DEQ_ANY = 2'd1;
  localparam req_t REQ_DEQ1    = 2'd2;
  localparam req_t REQ_DEQ0    = 2'd3;

  // classified commands passed from front to back
  typedef logic [2:0] op_t;
  localparam op_t OP_ENQ0 = 3'd0;
  localparam op_t OP_ENQ1 = 3'd1;
  localparam op_t OP_BAD  = 3'd2;
  localparam op_t OP_DEQA = 3'd3;
  localparam op_t OP_DEQ0 = 3'd4;
  localparam op_t OP_DEQ1 = 3'd5;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_DONE   = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_BADCLS = 2'd3;

  // class field values
  localparam logic [1:0] CLS_0    = 2'd0;
  localparam logic [1:0] CLS_1    = 2'd1;
  localparam logic [1:0] CLS_NONE = 2'b11;

endpackage
`default_nettype wire

// File: rtl/two_class_fifo_oldest_dequeue_core.sv
// two-class fifo with oldest-first dequeue
// input channel s_*: one request per item; s_tuser carries req_type
// (enqueue, dequeue any, dequeue class 1, dequeue class 0), s_tdata the
// id and class used by an enqueue
// output channel m_*: exactly one result item per request: dequeued id
// and class (both all ones when nothing is dequeued) plus a status code
// a dequeue-any pops the head with the smaller id, class 0 on a tie
// structure: a front stage classifies requests into a two-entry command
// queue; the back stage owns the two id memories, pointers and counts
// an accepted item passes the command queue, the back stage's command
// latch and the result register; the back stage takes one command at
// a time: it latches a command while the registered memory reads of
// both heads settle and then compares, updates pointers and loads the
// result, before it takes the next; the front keeps taking items while
// the back is busy, until its two command slots are full
// a stalled m_tready holds the result register, the back stage then
// waits and the command queue fills, dropping s_tready
// reset (synchronous, rst high) empties both queues and the command
// queue; memory contents are not cleared, so no reset sweep is needed
`default_nettype none
module two_class_fifo_oldest_dequeue_core #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int ID_BITS     = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // item_id, item_class, zero padding
  input  wire [((ID_BITS+2+7)/8)*8-1:0]   s_tdata,
  // req_type
  input  wire [1:0]                       s_tuser,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // out_id, out_class, status, zero padding
  output logic [((ID_BITS+5+7)/8)*8-1:0]  m_tdata
);

  localparam int MDW = ((ID_BITS + 5 + 7) / 8) * 8;

  logic                       cmd_valid;
  logic                       cmd_pop;
  tcfq_pkg::op_t              cmd_op;
  logic [ID_BITS-1:0]         cmd_id;
  logic signed [ID_BITS:0]    out_id;
  logic signed [1:0]          out_class;
  tcfq_pkg::status_t          status;

  // front: accept and classify into the command queue
  tcfq_front #(
    .ID_BITS (ID_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (s_tuser),
    .in_id     (s_tdata[ID_BITS-1:0]),
    .in_class  (s_tdata[ID_BITS+1:ID_BITS]),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_op    (cmd_op),
    .cmd_id    (cmd_id)
  );

  // back: queues, head compare and result register
  tcfq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_op    (cmd_op),
    .cmd_id    (cmd_id),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .out_id    (out_id),
    .out_class (out_class),
    .status    (status)
  );

  // pack result fields from the lowest bit up, padding to whole bytes
  assign m_tdata = MDW'({status, out_class, out_id});

endmodule
`default_nettype wire

// File: rtl/tcfq_front.sv
`default_nettype none
module tcfq_front #(
  parameter int ID_BITS = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire tcfq_pkg::req_t     in_req,
  input  wire [ID_BITS-1:0]       in_id,
  input  wire [1:0]               in_class,
  output logic                    cmd_valid,
  input  wire                     cmd_pop,
  output tcfq_pkg::op_t           cmd_op,
  output logic [ID_BITS-1:0]      cmd_id
);

  // two-entry command queue
  tcfq_pkg::op_t      q_op [2];
  logic [ID_BITS-1:0] q_id [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         cnt;
  logic               push;
  tcfq_pkg::op_t      op_in;

  always_comb begin
    unique case (in_req)
      tcfq_pkg::REQ_ENQ: begin
        if (in_class == tcfq_pkg::CLS_0) begin
          op_in = tcfq_pkg::OP_ENQ0;
        end else if (in_class == tcfq_pkg::CLS_1) begin
          op_in = tcfq_pkg::OP_ENQ1;
        end else begin
          op_in = tcfq_pkg::OP_BAD;
        end
      end
      tcfq_pkg::REQ_DEQ_ANY: op_in = tcfq_pkg::OP_DEQA;
      tcfq_pkg::REQ_DEQ1:    op_in = tcfq_pkg::OP_DEQ1;
      tcfq_pkg::REQ_DEQ0:    op_in = tcfq_pkg::OP_DEQ0;
      default:               op_in = tcfq_pkg::OP_BAD;
    endcase
  end

  assign in_ready  = (cnt != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd_op    = q_op[rd_ptr];
  assign cmd_id    = q_id[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr] <= op_in;
      q_id[wr_ptr] <= in_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !cmd_pop) begin
        cnt <= cnt + 2'd1;
      end else if (!push && cmd_pop) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/tcfq_back.sv
`default_nettype none
module tcfq_back #(
  parameter int QUEUE_DEPTH = 1024,
  parameter int ID_BITS     = 16
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cmd_valid,
  output logic                       cmd_pop,
  input  wire tcfq_pkg::op_t         cmd_op,
  input  wire [ID_BITS-1:0]          cmd_id,
  output logic                       res_valid,
  input  wire                        res_ready,
  output logic signed [ID_BITS:0]    out_id,
  output logic signed [1:0]          out_class,
  output tcfq_pkg::status_t          status
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_ONE  = PW'(1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic               state;
  tcfq_pkg::op_t      op;
  logic [ID_BITS-1:0] id;

  logic [ID_BITS-1:0] mem0 [QUEUE_DEPTH];
  logic [ID_BITS-1:0] mem1 [QUEUE_DEPTH];
  logic [ID_BITS-1:0] rd0;
  logic [ID_BITS-1:0] rd1;

  logic [PW-1:0] head0, tail0, head1, tail1;
  logic [CW-1:0] count0, count1;

  logic              out_free, fire;
  logic              ne0, ne1, full0, full1;
  logic              wr0, wr1, pop0, pop1, neg, pick;
  tcfq_pkg::status_t st;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_ONE;
  endfunction

  assign out_free = !res_valid || res_ready;
  assign fire     = (state == S_EXEC) && out_free;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign ne0      = (count0 != '0);
  assign ne1      = (count1 != '0);
  assign full0    = (count0 == CNT_FULL);
  assign full1    = (count1 == CNT_FULL);

  always_comb begin
    wr0  = 1'b0;
    wr1  = 1'b0;
    neg  = 1'b1;
    pick = 1'b0;
    st   = tcfq_pkg::ST_DONE;
    unique case (op)
      tcfq_pkg::OP_ENQ0: begin
        if (full0) begin
          st = tcfq_pkg::ST_FULL;
        end else begin
          wr0 = 1'b1;
        end
      end
      tcfq_pkg::OP_ENQ1: begin
        if (full1) begin
          st = tcfq_pkg::ST_FULL;
        end else begin
          wr1 = 1'b1;
        end
      end
      tcfq_pkg::OP_BAD: st = tcfq_pkg::ST_BADCLS;
      tcfq_pkg::OP_DEQA: begin
        // older head wins, class 0 on a tie
        priority if (ne0 && ne1) begin
          neg  = 1'b0;
          pick = (rd1 < rd0);
        end else if (ne0) begin
          neg = 1'b0;
        end else if (ne1) begin
          neg  = 1'b0;
          pick = 1'b1;
        end else begin
          st = tcfq_pkg::ST_EMPTY;
        end
      end
      tcfq_pkg::OP_DEQ0: begin
        if (ne0) begin
          neg = 1'b0;
        end else begin
          st = tcfq_pkg::ST_EMPTY;
        end
      end
      tcfq_pkg::OP_DEQ1: begin
        if (ne1) begin
          neg  = 1'b0;
          pick = 1'b1;
        end else begin
          st = tcfq_pkg::ST_EMPTY;
        end
      end
      default: st = tcfq_pkg::ST_BADCLS;
    endcase
    pop0 = !neg && !pick;
    pop1 = !neg && pick;
  end

  // head entries are read every cycle; they are stable once a command is latched
  always_ff @(posedge clk) begin
    rd0 <= mem0[head0];
    rd1 <= mem1[head1];
    if (fire && wr0) begin
      mem0[tail0] <= id;
    end
    if (fire && wr1) begin
      mem1[tail1] <= id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      op <= cmd_op;
      id <= cmd_id;
    end
    if (fire) begin
      out_id    <= neg ? '1 : {1'b0, (pick ? rd1 : rd0)};
      out_class <= neg ? tcfq_pkg::CLS_NONE : {1'b0, pick};
      status    <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      head0     <= '0;
      tail0     <= '0;
      head1     <= '0;
      tail1     <= '0;
      count0    <= '0;
      count1    <= '0;
    end else begin
      if (cmd_pop) begin
        state <= S_EXEC;
      end else if (fire) begin
        state <= S_IDLE;
      end
      if (fire) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (fire) begin
        if (wr0) begin
          tail0  <= ptr_inc(tail0);
          count0 <= count0 + CNT_ONE;
        end
        if (wr1) begin
          tail1  <= ptr_inc(tail1);
          count1 <= count1 + CNT_ONE;
        end
        if (pop0) begin
          head0  <= ptr_inc(head0);
          count0 <= count0 - CNT_ONE;
        end
        if (pop1) begin
          head1  <= ptr_inc(head1);
          count1 <= count1 - CNT_ONE;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/tcfq_checker.sv
`default_nettype none
module tcfq_checker #(
  parameter int ID_BITS = 16
) (
  input wire                             clk,
  input wire                             rst,
  input wire                             m_tvalid,
  input wire                             m_tready,
  input wire [((ID_BITS+5+7)/8)*8-1:0]   m_tdata
);

  logic [ID_BITS:0] c_id;
  logic [1:0]       c_class;
  logic [1:0]       c_status;

  assign c_id     = m_tdata[ID_BITS:0];
  assign c_class  = m_tdata[ID_BITS+2:ID_BITS+1];
  assign c_status = m_tdata[ID_BITS+4:ID_BITS+3];

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // anything but a successful dequeue or enqueue carries no id and no class
  a_fail_marks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (c_status != tcfq_pkg::ST_DONE) |->
      (c_id == '1) && (c_class == tcfq_pkg::CLS_NONE))
    else $error("failed request shows an id or class");

  // a dequeued item names class 0 or 1 and a non-negative id
  a_deq_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (c_class != tcfq_pkg::CLS_NONE) |->
      (c_status == tcfq_pkg::ST_DONE) && !c_id[ID_BITS] && !c_class[1])
    else $error("dequeued item fields inconsistent");

endmodule

bind two_class_fifo_oldest_dequeue_core tcfq_checker #(
  .ID_BITS (ID_BITS)
) u_tcfq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
module testbench;

  localparam int DEPTH  = 1024;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 24;

  // one request as offered on the input channel
  typedef struct {
    tcfq_pkg::req_t req;
    logic [15:0]    id;
    logic [1:0]     cls;
  } request_t;

  // one result as it should leave the output channel
  typedef struct {
    logic signed [16:0] id;
    logic [1:0]         cls;
    tcfq_pkg::status_t  st;
  } result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  wire              s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // item_id, item_class, zero padding
  logic [1:0]       s_tuser = '0;   // req_type
  wire              m_tvalid;
  logic             m_tready = 1'b0;
  wire [OUT_W-1:0]  m_tdata;        // out_id, out_class, status, zero padding

  two_class_fifo_oldest_dequeue_core #(
    .QUEUE_DEPTH(DEPTH),
    .ID_BITS(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  request_t    pending_reqs[$];
  result_t     awaited_results[$];
  logic [15:0] class0_ids[$];
  logic [15:0] class1_ids[$];
  logic [15:0] next_id = 16'd1000;
  int          errors = 0;
  int          cyc = 0;
  int          hold_left = 0;
  logic        in_taken = 1'b0;
  request_t    nxt;
  result_t     want;

  // long stretch of cycles with no random idling on either side
  wire quiet = (cyc >= 2000) && (cyc < 3500);

  // the shelter itself: two id fifos, dequeue-any takes the smaller head
  function automatic result_t serve_request(tcfq_pkg::req_t req, logic [15:0] id,
                                            logic [1:0] cls);
    result_t r;
    logic    pick;
    logic    found;
    r.id  = '1;
    r.cls = tcfq_pkg::CLS_NONE;
    r.st  = tcfq_pkg::ST_DONE;
    pick  = 1'b0;
    found = 1'b1;
    case (req)
      tcfq_pkg::REQ_ENQ: begin
        if (cls != tcfq_pkg::CLS_0 && cls != tcfq_pkg::CLS_1) begin
          r.st = tcfq_pkg::ST_BADCLS;
        end else if (cls == tcfq_pkg::CLS_0) begin
          if (class0_ids.size() >= DEPTH) r.st = tcfq_pkg::ST_FULL;
          else class0_ids.push_back(id);
        end else begin
          if (class1_ids.size() >= DEPTH) r.st = tcfq_pkg::ST_FULL;
          else class1_ids.push_back(id);
        end
        return r;
      end
      tcfq_pkg::REQ_DEQ_ANY: begin
        if (class0_ids.size() != 0 && class1_ids.size() != 0)
          pick = (class1_ids[0] < class0_ids[0]);
        else if (class0_ids.size() != 0)
          pick = 1'b0;
        else if (class1_ids.size() != 0)
          pick = 1'b1;
        else
          found = 1'b0;
      end
      tcfq_pkg::REQ_DEQ1: begin
        pick  = 1'b1;
        found = (class1_ids.size() != 0);
      end
      default: begin
        pick  = 1'b0;
        found = (class0_ids.size() != 0);
      end
    endcase
    if (!found) begin
      r.st = tcfq_pkg::ST_EMPTY;
    end else if (pick) begin
      r.id  = {1'b0, class1_ids.pop_front()};
      r.cls = tcfq_pkg::CLS_1;
    end else begin
      r.id  = {1'b0, class0_ids.pop_front()};
      r.cls = tcfq_pkg::CLS_0;
    end
    return r;
  endfunction

  task automatic add_req(tcfq_pkg::req_t req, logic [15:0] id, logic [1:0] cls);
    request_t q;
    q.req = req;
    q.id  = id;
    q.cls = cls;
    pending_reqs.push_back(q);
  endtask

  // dequeues carry junk in the id and class fields, which must be ignored
  task automatic add_deq(tcfq_pkg::req_t req);
    add_req(req, 16'($urandom()), 2'($urandom()));
  endtask

  // ids rise with arrival, with occasional repeats to give ties
  function automatic logic [15:0] fresh_id();
    next_id = next_id + 16'($urandom_range(0, 2));
    return next_id;
  endfunction

  // sender: offers the next pending item at the falling edge
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || in_taken)) begin
      if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
        nxt = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.req;
        s_tdata  <= IN_W'({nxt.cls, nxt.id});
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus two long hold-offs that back the block up
  always @(negedge clk) begin
    if (cyc == 700 || cyc == 6000) hold_left = 400;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(0, 99) >= 6);
    end
  end

  // monitor: check results first, then predict from the accepted request
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $error("result item with no expectation waiting: m_tdata=%h", m_tdata);
      end else begin
        want = awaited_results.pop_front();
        if ($signed(m_tdata[16:0]) !== want.id) begin
          errors++;
          $error("out_id: expected %0d, got %0d", want.id, $signed(m_tdata[16:0]));
        end
        if (m_tdata[18:17] !== want.cls) begin
          errors++;
          $error("out_class: expected %0d, got %0d", $signed(want.cls),
                 $signed(m_tdata[18:17]));
        end
        if (m_tdata[20:19] !== want.st) begin
          errors++;
          $error("status: expected %0d, got %0d", want.st, m_tdata[20:19]);
        end
      end
    end
    if (!rst && s_tvalid && s_tready)
      awaited_results.push_back(serve_request(s_tuser, s_tdata[15:0], s_tdata[17:16]));
    in_taken = !rst && s_tvalid && s_tready;
  end

  initial begin
    int k;
    int pick;

    // directed: empty dequeues, bad classes, ties, id extremes
    add_deq(tcfq_pkg::REQ_DEQ_ANY);
    add_deq(tcfq_pkg::REQ_DEQ0);
    add_deq(tcfq_pkg::REQ_DEQ1);
    add_req(tcfq_pkg::REQ_ENQ, 16'hffff, 2'd2);
    add_req(tcfq_pkg::REQ_ENQ, 16'h0000, 2'd3);
    add_req(tcfq_pkg::REQ_ENQ, 16'h0000, tcfq_pkg::CLS_0);
    add_req(tcfq_pkg::REQ_ENQ, 16'h0000, tcfq_pkg::CLS_1);
    add_deq(tcfq_pkg::REQ_DEQ_ANY);                // tie goes to class 0
    add_deq(tcfq_pkg::REQ_DEQ_ANY);
    add_req(tcfq_pkg::REQ_ENQ, 16'hffff, tcfq_pkg::CLS_0);
    add_req(tcfq_pkg::REQ_ENQ, 16'd100, tcfq_pkg::CLS_1);
    add_deq(tcfq_pkg::REQ_DEQ_ANY);                // class 1 head is smaller
    add_deq(tcfq_pkg::REQ_DEQ_ANY);
    add_req(tcfq_pkg::REQ_ENQ, 16'd5, tcfq_pkg::CLS_1);
    add_req(tcfq_pkg::REQ_ENQ, 16'd7, tcfq_pkg::CLS_0);
    add_deq(tcfq_pkg::REQ_DEQ0);
    add_deq(tcfq_pkg::REQ_DEQ1);
    add_req(tcfq_pkg::REQ_ENQ, 16'd10, tcfq_pkg::CLS_0);
    add_deq(tcfq_pkg::REQ_DEQ_ANY);                // only class 0 holds anything
    add_req(tcfq_pkg::REQ_ENQ, 16'd11, tcfq_pkg::CLS_1);
    add_deq(tcfq_pkg::REQ_DEQ_ANY);                // only class 1 holds anything
    add_req(tcfq_pkg::REQ_ENQ, 16'h5555, tcfq_pkg::CLS_0);
    add_req(tcfq_pkg::REQ_ENQ, 16'haaaa, tcfq_pkg::CLS_1);
    add_deq(tcfq_pkg::REQ_DEQ1);
    add_deq(tcfq_pkg::REQ_DEQ0);

    // fill class 0 to the brim across the pointer wrap, then overflow it
    for (k = 0; k < DEPTH; k++) add_req(tcfq_pkg::REQ_ENQ, fresh_id(), tcfq_pkg::CLS_0);
    add_req(tcfq_pkg::REQ_ENQ, fresh_id(), tcfq_pkg::CLS_0);
    add_deq(tcfq_pkg::REQ_DEQ0);
    add_req(tcfq_pkg::REQ_ENQ, fresh_id(), tcfq_pkg::CLS_0);
    add_req(tcfq_pkg::REQ_ENQ, fresh_id(), tcfq_pkg::CLS_0);
    add_req(tcfq_pkg::REQ_ENQ, fresh_id(), tcfq_pkg::CLS_1);

    // random traffic on top of the full class 0 queue
    for (k = 0; k < 240; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 46)
        add_req(tcfq_pkg::REQ_ENQ,
                ($urandom_range(0, 9) == 0) ? 16'($urandom()) : fresh_id(),
                2'($urandom_range(0, 1)));
      else if (pick < 51)
        add_req(tcfq_pkg::REQ_ENQ, 16'($urandom()), 2'($urandom_range(2, 3)));
      else if (pick < 72)
        add_deq(tcfq_pkg::REQ_DEQ_ANY);
      else if (pick < 86)
        add_deq(tcfq_pkg::REQ_DEQ0);
      else
        add_deq(tcfq_pkg::REQ_DEQ1);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("two_class_fifo_oldest_dequeue_core verification clean");
    else
      $display("two_class_fifo_oldest_dequeue_core verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("two_class_fifo_oldest_dequeue_core verification failed");
    $finish;
  end

endmodule
